FILE: design/mmm_pkg.sv
`timescale 1ns / 1ps

package mmm_pkg;

  localparam int WIDTH      = 32;
  localparam int ACC_W      = WIDTH + 1;
  localparam int MOD_W      = 31;
  localparam int CNT_W      = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] REG_MODULUS   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_COUNT = 1'd1;

  localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1;
  localparam logic [CNT_W-1:0] COUNT_RESET   = 6'd32;

  typedef struct packed {
    logic load;
    logic step;
    logic sub;
    logic out_load;
  } mmm_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic last_step;
  } mmm_status_t;

endpackage

FILE: design/mmm_if.sv
`timescale 1ns / 1ps

interface mmm_in_if;
  import mmm_pkg::*;

  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] x_operand;
  logic [MOD_W-1:0] y_operand;

  modport source (output valid, output x_operand, output y_operand, input ready);
  modport sink   (input valid, input x_operand, input y_operand, output ready);
endinterface

interface mmm_out_if;
  import mmm_pkg::*;

  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] product;

  modport source (output valid, output product, input ready);
  modport sink   (input valid, input product, output ready);
endinterface

FILE: design/montgomery_modular_multiply.sv
`timescale 1ns / 1ps

// Radix-2 Montgomery multiplier: product = x * y * 2^-bit_count mod modulus.
// Input beats on in_ch carry x_operand and y_operand; each gives exactly one
// beat on out_ch carrying product. Both channels move a beat on valid && ready.
// modulus and bit_count are written through cfg_write / cfg_index / cfg_data
// (index 0 modulus, index 1 bit_count); the user must write them only while
// the block is idle, which the block itself does not enforce.
// One x bit is scanned per cycle by the shared add-and-halve step, then the
// FIX state does the first conditional subtraction, the second being folded
// into the output register load. One item is in work at a time: a new input
// beat is taken only after the last result has gone to the output register.
// The output register lets the next input beat be taken while a result still
// waits; if the receiver stalls, a finished item holds in the send state until
// the output register drains, and in_ch.ready stays low meanwhile.
// Reset (rst, synchronous) returns modulus to 1, bit_count to 32, empties the
// output register and leaves the block ready for input.
module montgomery_modular_multiply (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [mmm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mmm_pkg::CFG_DATA_W-1:0] cfg_data,
  mmm_in_if.sink                         in_ch,
  mmm_out_if.source                      out_ch
);
  import mmm_pkg::*;

  mmm_cmd_t    cmd;
  mmm_status_t status;

  mmm_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  mmm_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .x_operand (in_ch.x_operand),
    .y_operand (in_ch.y_operand),
    .cmd       (cmd),
    .status    (status),
    .product   (out_ch.product)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken again straight after a beat");

  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("output register overwritten while a result waits");

  a_step_follows_accept: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready && !status.count_zero) |=> cmd.step)
    else $error("scan did not start after an input beat");

  a_out_after_fix: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !cmd.step && !cmd.load)
    else $error("output load overlaps a scan or a new item");

endmodule

FILE: design/mmm_datapath.sv
`timescale 1ns / 1ps

module mmm_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [mmm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mmm_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [mmm_pkg::WIDTH-1:0]         x_operand,
  input  logic [mmm_pkg::MOD_W-1:0]         y_operand,
  input  mmm_pkg::mmm_cmd_t                 cmd,
  output mmm_pkg::mmm_status_t              status,
  output logic [mmm_pkg::WIDTH-1:0]         product
);
  import mmm_pkg::*;

  logic [MOD_W-1:0] modulus;
  logic [CNT_W-1:0] bit_count;

  logic [ACC_W-1:0] accumulator;
  logic [WIDTH-1:0] x_shift;
  logic [MOD_W-1:0] y_hold;
  logic [CNT_W-1:0] step_counter;

  logic             eta;
  logic             x_bit;
  logic [ACC_W:0]   sum;
  logic [ACC_W-1:0] m_ext;
  logic [ACC_W-1:0] fixed;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus   <= MODULUS_RESET;
      bit_count <= COUNT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MODULUS:   modulus   <= cfg_data[MOD_W-1:0];
        REG_BIT_COUNT: bit_count <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign x_bit = x_shift[0];
  assign eta   = accumulator[0] ^ (x_bit & y_hold[0]);
  assign m_ext = {{(ACC_W-MOD_W){1'b0}}, modulus};

  always_comb begin
    sum = {1'b0, accumulator};
    if (x_bit) sum = sum + {{(ACC_W+1-MOD_W){1'b0}}, y_hold};
    if (eta)   sum = sum + {{(ACC_W+1-MOD_W){1'b0}}, modulus};
  end

  assign fixed = (accumulator >= m_ext) ? (accumulator - m_ext) : accumulator;

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator  <= '0;
      x_shift      <= '0;
      step_counter <= '0;
    end else if (cmd.load) begin
      accumulator  <= '0;
      x_shift      <= x_operand;
      step_counter <= '0;
    end else if (cmd.step) begin
      accumulator  <= sum[ACC_W:1];
      x_shift      <= {1'b0, x_shift[WIDTH-1:1]};
      step_counter <= step_counter + CNT_W'(1);
    end else if (cmd.sub) begin
      accumulator  <= fixed;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) y_hold <= y_operand;
  end

  // second conditional subtraction folds into the output register load
  always_ff @(posedge clk) begin
    if (cmd.out_load) product <= fixed[WIDTH-1:0];
  end

  assign status.count_zero = (bit_count == '0);
  assign status.last_step  = (step_counter == bit_count - CNT_W'(1));

endmodule

FILE: design/mmm_controller.sv
`timescale 1ns / 1ps

module mmm_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  mmm_pkg::mmm_status_t status,
  output mmm_pkg::mmm_cmd_t    cmd
);
  import mmm_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIX  = 2'd2;
  localparam logic [1:0] ST_SEND = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next   = state;
    cmd.load     = 1'b0;
    cmd.step     = 1'b0;
    cmd.sub      = 1'b0;
    cmd.out_load = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.count_zero ? ST_FIX : ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        if (status.last_step) state_next = ST_FIX;
      end
      ST_FIX: begin
        cmd.sub    = 1'b1;
        state_next = ST_SEND;
      end
      ST_SEND: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule
